/* rtl/moi_pkg.sv */
// Package with shared types, constants and tables for the mecanum odometry integrator.
`timescale 1ns / 1ps

package moi_pkg;

    // CORDIC iteration count and derived widths.
    localparam int CORDIC_STEPS = 24;
    localparam int CSTEP_W      = $clog2(CORDIC_STEPS);
    localparam int CORDIC_W     = 34;
    localparam int ATAN_IDX_W   = 5;
    localparam logic signed [CORDIC_W-1:0] CORDIC_GAIN = 34'sd652032874;

    // Register reset and fixed scale factors.
    localparam logic [23:0] SPEED_SCALE_RESET = 24'd450218;
    localparam logic [25:0] HEAD_K            = 26'd44798134;
    localparam int          US_PER_S          = 1000000;
    localparam int          US_HALF           = US_PER_S / 2;

    // Shared multiplier operand and product widths.
    localparam int MUL_A_W = 28;
    localparam int MUL_B_W = 35;
    localparam int PROD_W  = MUL_A_W + MUL_B_W;

    // Divider by one million. One million is 64 times 15625, so the biased magnitude
    // is shifted right by six and multiplied by the rounded-up reciprocal of 15625
    // in Q54, using four 21 by 21 bit partial products.
    localparam int DIV_IN_W   = 47;
    localparam int DIV_PRE_SH = 6;
    localparam int DIV_N_W    = DIV_IN_W - DIV_PRE_SH;
    localparam int DIV_LO_W   = 21;
    localparam int DIV_OP_W   = 21;
    localparam int RECIP_W    = 41;
    localparam logic [RECIP_W-1:0] RECIP_15625 = 41'd1152921504607;
    localparam int RECIP_SH   = 54;
    localparam int DIV_ACC_W  = DIV_N_W + RECIP_W;
    localparam int DIV_PASSES = 4;
    localparam int QUOT_W     = 29;

    // Input request payload.
    typedef struct packed {
        logic               action;
        logic signed [15:0] front_left_rpm;
        logic signed [15:0] front_right_rpm;
        logic signed [15:0] back_left_rpm;
        logic signed [15:0] back_right_rpm;
        logic signed [19:0] yaw_rate_in;
        logic        [19:0] elapsed_us;
    } in_item_t;

    // Result request payload.
    typedef struct packed {
        logic signed [31:0] pos_x;
        logic signed [31:0] pos_y;
        logic signed [31:0] heading;
        logic signed [31:0] vel_x;
        logic signed [31:0] vel_y;
        logic signed [19:0] yaw_rate_out;
    } out_item_t;

    // Action codes of an input request.
    localparam logic ACT_IMU     = 1'b0;
    localparam logic ACT_ENCODER = 1'b1;

    // Controller states.
    typedef enum logic [4:0] {
        ST_IDLE, ST_MVX, ST_MVY, ST_VY, ST_CORDIC, ST_FIX,
        ST_M1, ST_M2, ST_M3, ST_M4, ST_M5, ST_M6, ST_M7, ST_M8,
        ST_M9, ST_M10, ST_M11, ST_DONE
    } state_t;

    // Operand selection of the shared multiplier.
    typedef enum logic [3:0] {
        MUL_NONE, MUL_SX_SCALE, MUL_SY_SCALE, MUL_VX_C, MUL_VY_S, MUL_VX_S,
        MUL_VY_C, MUL_WX_DT, MUL_WY_DT, MUL_RATE_DT, MUL_HI_K, MUL_LO_K
    } mul_sel_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic               load;
        mul_sel_t           mul_sel;
        logic               vx_en;
        logic               vy_en;
        logic               cordic_step;
        logic [CSTEP_W-1:0] cordic_idx;
        logic               cs_en;
        logic               acc_en;
        logic               wx_en;
        logic               wy_en;
        logic               divx_start;
        logic               divy_start;
        logic               pmag_en;
        logic               hd_en;
        logic               commit;
    } dp_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic div_done;
    } dp_sts_t;

    // Arctangent table, binary angle with 2^31 equal to pi.
    function automatic logic [31:0] cordic_atan(input logic [ATAN_IDX_W-1:0] idx);
        logic [31:0] r;
        unique case (idx)
            5'd0:  r = 32'h20000000;
            5'd1:  r = 32'h12E4051E;
            5'd2:  r = 32'h09FB385B;
            5'd3:  r = 32'h051111D4;
            5'd4:  r = 32'h028B0D43;
            5'd5:  r = 32'h0145D7E1;
            5'd6:  r = 32'h00A2F61E;
            5'd7:  r = 32'h00517C55;
            5'd8:  r = 32'h0028BE53;
            5'd9:  r = 32'h00145F2F;
            5'd10: r = 32'h000A2F98;
            5'd11: r = 32'h000517CC;
            5'd12: r = 32'h00028BE6;
            5'd13: r = 32'h000145F3;
            5'd14: r = 32'h0000A2FA;
            5'd15: r = 32'h0000517D;
            5'd16: r = 32'h000028BE;
            5'd17: r = 32'h0000145F;
            5'd18: r = 32'h00000A30;
            5'd19: r = 32'h00000518;
            5'd20: r = 32'h0000028C;
            5'd21: r = 32'h00000146;
            5'd22: r = 32'h000000A3;
            5'd23: r = 32'h00000051;
            5'd24: r = 32'h00000029;
            5'd25: r = 32'h00000014;
            5'd26: r = 32'h0000000A;
            5'd27: r = 32'h00000005;
            5'd28: r = 32'h00000003;
            5'd29: r = 32'h00000001;
            5'd30: r = 32'h00000001;
            default: r = 32'h00000000;
        endcase
        return r;
    endfunction

endpackage

/* rtl/mecanum_odometry_integrator.sv */
// Flow: an IMU request is taken while idle and leaves the block idle; an encoder request
// goes through velocity forming, 24 CORDIC iterations, a fold step, eleven shared
// multiplier steps and a commit step. The dividers by one million overlap the multiplier
// steps. A result not taken holds the commit.
// Throughput: a new request is taken only after an encoder request is committed; IMU
// requests one per cycle while idle. Reset: synchronous active-low aresetn clears pose,
// yaw rate and control, and loads the speed scale with its default.
`timescale 1ns / 1ps

module mecanum_odometry_integrator (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               cfg_wr_en,
    input  logic [23:0]        cfg_wr_data,
    input  logic               s_valid,
    output logic               s_ready,
    input  moi_pkg::in_item_t  s_data,
    output logic               m_valid,
    input  logic               m_ready,
    output moi_pkg::out_item_t m_data
);

    moi_pkg::dp_cmd_t cmd;
    moi_pkg::dp_sts_t sts;

    // Sequencer.
    moi_ctrl u_ctrl (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .in_action (s_data.action),
        .s_ready   (s_ready),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .sts       (sts),
        .cmd       (cmd)
    );

    // Arithmetic and state.
    moi_datapath u_dp (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .in_item     (s_data),
        .cmd         (cmd),
        .sts         (sts),
        .out_item    (m_data)
    );

    // An IMU request returns the block to idle at once.
    assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready && s_data.action == moi_pkg::ACT_IMU |=> s_ready)
        else $error("IMU request did not leave the block idle");

    // An encoder request keeps the input closed while it is worked on.
    assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready && s_data.action == moi_pkg::ACT_ENCODER |=> !s_ready)
        else $error("encoder request did not start processing");

    // A new result only appears at the end of processing.
    assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid) |-> $past(!s_ready))
        else $error("result appeared while idle");

endmodule

/* rtl/moi_div_const.sv */
// Signed rounding divider by one million by reciprocal multiplication over four partial products.
`timescale 1ns / 1ps

module moi_div_const (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              start,
    input  logic signed [moi_pkg::PROD_W-1:0] dividend,
    output logic signed [moi_pkg::QUOT_W-1:0] quot,
    output logic                              done
);

    logic [2:0]                          cnt_reg;
    logic                                neg_reg;
    logic [moi_pkg::DIV_N_W-1:0]         n_reg;
    logic [moi_pkg::DIV_ACC_W-1:0]       acc_reg;
    logic [moi_pkg::PROD_W-1:0]          mag;
    logic [moi_pkg::DIV_IN_W-1:0]        biased;
    logic [moi_pkg::DIV_OP_W-1:0]        op_a, op_b;
    logic [2*moi_pkg::DIV_OP_W-1:0]      pp;
    logic [6:0]                          pp_sh;
    logic [moi_pkg::DIV_ACC_W-1:0]       pp_ext;
    logic [moi_pkg::QUOT_W-1:0]          q_pos;

    // Magnitude of the dividend plus half the divisor, so the floor rounds to nearest.
    assign mag    = dividend[moi_pkg::PROD_W-1] ? moi_pkg::PROD_W'(-dividend)
                                                : moi_pkg::PROD_W'(dividend);
    assign biased = mag[moi_pkg::DIV_IN_W-1:0] + moi_pkg::DIV_IN_W'(moi_pkg::US_HALF);

    // Partial product of one half of the shifted dividend and one half of the reciprocal.
    always_comb begin
        op_a  = '0;
        op_b  = '0;
        pp_sh = '0;
        case (cnt_reg)
            3'd4: begin
                op_a = n_reg[moi_pkg::DIV_LO_W-1:0];
                op_b = moi_pkg::RECIP_15625[moi_pkg::DIV_LO_W-1:0];
            end
            3'd3: begin
                op_a  = n_reg[moi_pkg::DIV_LO_W-1:0];
                op_b  = {1'b0, moi_pkg::RECIP_15625[moi_pkg::RECIP_W-1:moi_pkg::DIV_LO_W]};
                pp_sh = 7'(moi_pkg::DIV_LO_W);
            end
            3'd2: begin
                op_a  = {1'b0, n_reg[moi_pkg::DIV_N_W-1:moi_pkg::DIV_LO_W]};
                op_b  = moi_pkg::RECIP_15625[moi_pkg::DIV_LO_W-1:0];
                pp_sh = 7'(moi_pkg::DIV_LO_W);
            end
            3'd1: begin
                op_a  = {1'b0, n_reg[moi_pkg::DIV_N_W-1:moi_pkg::DIV_LO_W]};
                op_b  = {1'b0, moi_pkg::RECIP_15625[moi_pkg::RECIP_W-1:moi_pkg::DIV_LO_W]};
                pp_sh = 7'(2 * moi_pkg::DIV_LO_W);
            end
            default: begin
                op_a  = '0;
                op_b  = '0;
                pp_sh = '0;
            end
        endcase
    end

    assign pp     = op_a * op_b;
    assign pp_ext = moi_pkg::DIV_ACC_W'(pp) << pp_sh;

    // Pass counter.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg <= '0;
        end else if (start) begin
            cnt_reg <= 3'(moi_pkg::DIV_PASSES);
        end else if (cnt_reg != '0) begin
            cnt_reg <= cnt_reg - 1'b1;
        end
    end

    // Shifted dividend, sign and product accumulator.
    always_ff @(posedge aclk) begin
        if (start) begin
            neg_reg <= dividend[moi_pkg::PROD_W-1];
            n_reg   <= biased[moi_pkg::DIV_IN_W-1:moi_pkg::DIV_PRE_SH];
            acc_reg <= '0;
        end else if (cnt_reg != '0) begin
            acc_reg <= acc_reg + pp_ext;
        end
    end

    // Signed quotient, ties away from zero.
    assign q_pos = {1'b0, acc_reg[moi_pkg::DIV_ACC_W-1:moi_pkg::RECIP_SH]};
    assign quot  = neg_reg ? -$signed(q_pos) : $signed(q_pos);
    assign done  = (cnt_reg == '0);

endmodule

/* rtl/moi_ctrl.sv */
// Controller state machine that sequences the odometry datapath.
`timescale 1ns / 1ps

module moi_ctrl (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             s_valid,
    input  logic             in_action,
    output logic             s_ready,
    output logic             m_valid,
    input  logic             m_ready,
    input  moi_pkg::dp_sts_t sts,
    output moi_pkg::dp_cmd_t cmd
);

    moi_pkg::state_t                 state_reg, state_next;
    logic [moi_pkg::CSTEP_W-1:0]     cnt_reg, cnt_next;
    logic                            m_valid_reg, m_valid_next;

    // State, iteration counter and result valid registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= moi_pkg::ST_IDLE;
            cnt_reg     <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            cnt_reg     <= cnt_next;
            m_valid_reg <= m_valid_next;
        end
    end

    // Next state and commands.
    always_comb begin
        state_next     = state_reg;
        cnt_next       = cnt_reg;
        cmd            = '0;
        cmd.mul_sel    = moi_pkg::MUL_NONE;
        cmd.cordic_idx = cnt_reg;
        s_ready        = 1'b0;
        unique case (state_reg)
            moi_pkg::ST_IDLE: begin
                s_ready  = 1'b1;
                cmd.load = s_valid;
                if (s_valid && in_action == moi_pkg::ACT_ENCODER) begin
                    state_next = moi_pkg::ST_MVX;
                end
            end
            moi_pkg::ST_MVX: begin
                cmd.mul_sel = moi_pkg::MUL_SX_SCALE;
                state_next  = moi_pkg::ST_MVY;
            end
            moi_pkg::ST_MVY: begin
                cmd.vx_en   = 1'b1;
                cmd.mul_sel = moi_pkg::MUL_SY_SCALE;
                state_next  = moi_pkg::ST_VY;
            end
            moi_pkg::ST_VY: begin
                cmd.vy_en  = 1'b1;
                cnt_next   = '0;
                state_next = moi_pkg::ST_CORDIC;
            end
            moi_pkg::ST_CORDIC: begin
                cmd.cordic_step = 1'b1;
                if (cnt_reg == moi_pkg::CSTEP_W'(moi_pkg::CORDIC_STEPS - 1)) begin
                    state_next = moi_pkg::ST_FIX;
                end else begin
                    cnt_next = cnt_reg + 1'b1;
                end
            end
            moi_pkg::ST_FIX: begin
                cmd.cs_en  = 1'b1;
                state_next = moi_pkg::ST_M1;
            end
            moi_pkg::ST_M1: begin
                cmd.mul_sel = moi_pkg::MUL_VX_C;
                state_next  = moi_pkg::ST_M2;
            end
            moi_pkg::ST_M2: begin
                cmd.acc_en  = 1'b1;
                cmd.mul_sel = moi_pkg::MUL_VY_S;
                state_next  = moi_pkg::ST_M3;
            end
            moi_pkg::ST_M3: begin
                cmd.wx_en   = 1'b1;
                cmd.mul_sel = moi_pkg::MUL_VX_S;
                state_next  = moi_pkg::ST_M4;
            end
            moi_pkg::ST_M4: begin
                cmd.acc_en  = 1'b1;
                cmd.mul_sel = moi_pkg::MUL_VY_C;
                state_next  = moi_pkg::ST_M5;
            end
            moi_pkg::ST_M5: begin
                cmd.wy_en   = 1'b1;
                cmd.mul_sel = moi_pkg::MUL_WX_DT;
                state_next  = moi_pkg::ST_M6;
            end
            moi_pkg::ST_M6: begin
                cmd.divx_start = 1'b1;
                cmd.mul_sel    = moi_pkg::MUL_WY_DT;
                state_next     = moi_pkg::ST_M7;
            end
            moi_pkg::ST_M7: begin
                cmd.divy_start = 1'b1;
                cmd.mul_sel    = moi_pkg::MUL_RATE_DT;
                state_next     = moi_pkg::ST_M8;
            end
            moi_pkg::ST_M8: begin
                cmd.pmag_en = 1'b1;
                state_next  = moi_pkg::ST_M9;
            end
            moi_pkg::ST_M9: begin
                cmd.mul_sel = moi_pkg::MUL_HI_K;
                state_next  = moi_pkg::ST_M10;
            end
            moi_pkg::ST_M10: begin
                cmd.acc_en  = 1'b1;
                cmd.mul_sel = moi_pkg::MUL_LO_K;
                state_next  = moi_pkg::ST_M11;
            end
            moi_pkg::ST_M11: begin
                cmd.hd_en  = 1'b1;
                state_next = moi_pkg::ST_DONE;
            end
            moi_pkg::ST_DONE: begin
                if (sts.div_done && (!m_valid_reg || m_ready)) begin
                    cmd.commit = 1'b1;
                    state_next = moi_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = moi_pkg::ST_IDLE;
            end
        endcase
    end

    // Result valid: set on commit, cleared when the result is taken.
    always_comb begin
        m_valid_next = m_valid_reg;
        if (cmd.commit) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    assign m_valid = m_valid_reg;

endmodule

/* rtl/moi_datapath.sv */
// Datapath with velocity forming, CORDIC, shared multiplier and pose accumulators.
`timescale 1ns / 1ps

module moi_datapath (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                cfg_wr_en,
    input  logic [23:0]         cfg_wr_data,
    input  moi_pkg::in_item_t   in_item,
    input  moi_pkg::dp_cmd_t    cmd,
    output moi_pkg::dp_sts_t    sts,
    output moi_pkg::out_item_t  out_item
);

    localparam int CW = moi_pkg::CORDIC_W;
    localparam int PW = moi_pkg::PROD_W;

    // Configuration and architectural state.
    logic [23:0]        speed_scale_reg;
    logic signed [31:0] x_acc_reg, y_acc_reg;
    logic [31:0]        theta_reg;
    logic signed [19:0] yaw_reg;

    // Working registers of one encoder request.
    logic signed [18:0]     sum_x_reg, sum_y_reg;
    logic [19:0]            dt_reg;
    logic signed [26:0]     vx_reg, vy_reg;
    logic signed [CW-1:0]   cx_reg, cy_reg, cz_reg, c_reg, s_reg;
    logic                   flip_reg;
    logic signed [PW-1:0]   prod_reg;
    logic signed [63:0]     acc_reg;
    logic signed [27:0]     wx_reg, wy_reg;
    logic [39:0]            pmag_reg;
    logic                   pneg_reg;
    logic [31:0]            hd_reg;
    moi_pkg::out_item_t     out_reg;

    // Combinational helpers.
    logic signed [18:0]     fl, fr, bl, br;
    logic signed [CW-1:0]   z0, z_init;
    logic                   flip_init;
    logic signed [CW-1:0]   x_sh, y_sh, atan_v;
    logic signed [moi_pkg::MUL_A_W-1:0] mul_a;
    logic signed [moi_pkg::MUL_B_W-1:0] mul_b;
    logic signed [PW-1:0]   v_rnd;
    logic signed [63:0]     prod_ext, wx_sum, wy_sum, w_rnd_x, w_rnd_y;
    logic signed [40:0]     rate_p;
    logic [63:0]            h_sum;
    logic [31:0]            h_d;
    logic signed [moi_pkg::QUOT_W-1:0] qx, qy;
    logic                   done_x, done_y;
    logic signed [32:0]     x_sum, y_sum;
    logic signed [31:0]     x_new, y_new;

    // Wheel sums in body frame.
    assign fl = 19'(in_item.front_left_rpm);
    assign fr = 19'(in_item.front_right_rpm);
    assign bl = 19'(in_item.back_left_rpm);
    assign br = 19'(in_item.back_right_rpm);

    // Heading folded into the range of plus or minus a quarter turn.
    always_comb begin
        z0        = {{2{theta_reg[31]}}, theta_reg};
        z_init    = z0;
        flip_init = 1'b0;
        if (z0 > (CW'(1) <<< 30)) begin
            z_init    = z0 - (CW'(1) <<< 31);
            flip_init = 1'b1;
        end else if (z0 < -(CW'(1) <<< 30)) begin
            z_init    = z0 + (CW'(1) <<< 31);
            flip_init = 1'b1;
        end
    end

    // One CORDIC rotation step.
    assign x_sh   = cx_reg >>> cmd.cordic_idx;
    assign y_sh   = cy_reg >>> cmd.cordic_idx;
    assign atan_v = $signed({2'b00,
                    moi_pkg::cordic_atan(moi_pkg::ATAN_IDX_W'(cmd.cordic_idx))});

    // Shared multiplier operand selection.
    always_comb begin
        mul_a = '0;
        mul_b = '0;
        case (cmd.mul_sel)
            moi_pkg::MUL_SX_SCALE: begin
                mul_a = moi_pkg::MUL_A_W'(sum_x_reg);
                mul_b = $signed({11'd0, speed_scale_reg});
            end
            moi_pkg::MUL_SY_SCALE: begin
                mul_a = moi_pkg::MUL_A_W'(sum_y_reg);
                mul_b = $signed({11'd0, speed_scale_reg});
            end
            moi_pkg::MUL_VX_C: begin
                mul_a = moi_pkg::MUL_A_W'(vx_reg);
                mul_b = moi_pkg::MUL_B_W'(c_reg);
            end
            moi_pkg::MUL_VY_S: begin
                mul_a = moi_pkg::MUL_A_W'(vy_reg);
                mul_b = moi_pkg::MUL_B_W'(s_reg);
            end
            moi_pkg::MUL_VX_S: begin
                mul_a = moi_pkg::MUL_A_W'(vx_reg);
                mul_b = moi_pkg::MUL_B_W'(s_reg);
            end
            moi_pkg::MUL_VY_C: begin
                mul_a = moi_pkg::MUL_A_W'(vy_reg);
                mul_b = moi_pkg::MUL_B_W'(c_reg);
            end
            moi_pkg::MUL_WX_DT: begin
                mul_a = wx_reg;
                mul_b = $signed({15'd0, dt_reg});
            end
            moi_pkg::MUL_WY_DT: begin
                mul_a = wy_reg;
                mul_b = $signed({15'd0, dt_reg});
            end
            moi_pkg::MUL_RATE_DT: begin
                mul_a = moi_pkg::MUL_A_W'(yaw_reg);
                mul_b = $signed({15'd0, dt_reg});
            end
            moi_pkg::MUL_HI_K: begin
                mul_a = $signed({8'd0, pmag_reg[39:20]});
                mul_b = $signed({9'd0, moi_pkg::HEAD_K});
            end
            moi_pkg::MUL_LO_K: begin
                mul_a = $signed({8'd0, pmag_reg[19:0]});
                mul_b = $signed({9'd0, moi_pkg::HEAD_K});
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    // Rounding of products.
    assign v_rnd    = (prod_reg + PW'(32768)) >>> 16;
    assign prod_ext = 64'(prod_reg);
    assign wx_sum   = acc_reg - prod_ext;
    assign wy_sum   = acc_reg + prod_ext;
    assign w_rnd_x  = (wx_sum + (64'sd1 <<< 29)) >>> 30;
    assign w_rnd_y  = (wy_sum + (64'sd1 <<< 29)) >>> 30;
    assign rate_p   = prod_reg[40:0];

    // Heading step: round half up on the magnitude, then restore the sign.
    assign h_sum = {acc_reg[43:0], 20'd0} + 64'(prod_reg) + (64'd1 << 31);
    assign h_d   = h_sum[63:32];

    // Dividers for the x and y position steps.
    moi_div_const u_div_x (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (cmd.divx_start),
        .dividend (prod_reg),
        .quot     (qx),
        .done     (done_x)
    );

    moi_div_const u_div_y (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (cmd.divy_start),
        .dividend (prod_reg),
        .quot     (qy),
        .done     (done_y)
    );

    assign sts.div_done = done_x && done_y;

    // Saturating position update.
    assign x_sum = 33'(x_acc_reg) + 33'(qx);
    assign y_sum = 33'(y_acc_reg) + 33'(qy);

    always_comb begin
        x_new = x_sum[31:0];
        if (x_sum > 33'sd2147483647) begin
            x_new = 32'sh7FFFFFFF;
        end else if (x_sum < -33'sd2147483648) begin
            x_new = 32'sh80000000;
        end
        y_new = y_sum[31:0];
        if (y_sum > 33'sd2147483647) begin
            y_new = 32'sh7FFFFFFF;
        end else if (y_sum < -33'sd2147483648) begin
            y_new = 32'sh80000000;
        end
    end

    // Configuration register and pose state.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            speed_scale_reg <= moi_pkg::SPEED_SCALE_RESET;
            x_acc_reg       <= '0;
            y_acc_reg       <= '0;
            theta_reg       <= '0;
            yaw_reg         <= '0;
        end else begin
            if (cfg_wr_en) begin
                speed_scale_reg <= cfg_wr_data;
            end
            if (cmd.load && in_item.action == moi_pkg::ACT_IMU) begin
                yaw_reg <= in_item.yaw_rate_in;
            end
            if (cmd.commit) begin
                x_acc_reg <= x_new;
                y_acc_reg <= y_new;
                theta_reg <= theta_reg + hd_reg;
            end
        end
    end

    // Working registers.
    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            sum_x_reg <= fl + bl - br - fr;
            sum_y_reg <= bl + br - fl - fr;
            dt_reg    <= in_item.elapsed_us;
            cx_reg    <= moi_pkg::CORDIC_GAIN;
            cy_reg    <= '0;
            cz_reg    <= z_init;
            flip_reg  <= flip_init;
        end
        if (cmd.cordic_step) begin
            if (!cz_reg[CW-1]) begin
                cx_reg <= cx_reg - y_sh;
                cy_reg <= cy_reg + x_sh;
                cz_reg <= cz_reg - atan_v;
            end else begin
                cx_reg <= cx_reg + y_sh;
                cy_reg <= cy_reg - x_sh;
                cz_reg <= cz_reg + atan_v;
            end
        end
        if (cmd.cs_en) begin
            c_reg <= flip_reg ? -cx_reg : cx_reg;
            s_reg <= flip_reg ? -cy_reg : cy_reg;
        end
        prod_reg <= mul_a * mul_b;
        if (cmd.vx_en) begin
            vx_reg <= v_rnd[26:0];
        end
        if (cmd.vy_en) begin
            vy_reg <= v_rnd[26:0];
        end
        if (cmd.acc_en) begin
            acc_reg <= prod_ext;
        end
        if (cmd.wx_en) begin
            wx_reg <= w_rnd_x[27:0];
        end
        if (cmd.wy_en) begin
            wy_reg <= w_rnd_y[27:0];
        end
        if (cmd.pmag_en) begin
            pneg_reg <= rate_p[40];
            pmag_reg <= rate_p[40] ? 40'(-rate_p) : rate_p[39:0];
        end
        if (cmd.hd_en) begin
            hd_reg <= pneg_reg ? (32'd0 - h_d) : h_d;
        end
        if (cmd.commit) begin
            out_reg.pos_x        <= x_new;
            out_reg.pos_y        <= y_new;
            out_reg.heading      <= theta_reg + hd_reg;
            out_reg.vel_x        <= 32'(vx_reg);
            out_reg.vel_y        <= 32'(vy_reg);
            out_reg.yaw_rate_out <= yaw_reg;
        end
    end

    assign out_item = out_reg;

endmodule
